[rtl/dcc_pkg.sv]
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants of the dwell click controller: request action
// codes, button event codes, configuration register indexes and the
// configuration and result bundles passed between modules.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // Request action codes
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_PRESS   = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_TOGGLE  = 3'd3,
    ACT_ENABLE  = 3'd4,
    ACT_DISABLE = 3'd5
  } action_e;

  // Emitted button event codes
  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_PRESS   = 2'd1,
    EVT_RELEASE = 2'd2,
    EVT_CLICK   = 2'd3
  } btn_event_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MOVE_THRESHOLD = 3'd0,
    REG_DWELL_TICKS    = 3'd1,
    REG_DRAG_TICKS     = 3'd2,
    REG_DRAG_MODE      = 3'd3,
    REG_SOUND_ENABLE   = 3'd4,
    REG_EMIT_BUTTON    = 3'd5
  } cfg_index_e;

  localparam int CfgIndexBits = 3;
  localparam int ThrBits      = 8;
  localparam int ThrSqBits    = 2 * ThrBits;
  localparam int CodeBits     = 8;
  localparam int BtnNumBits   = 5;
  localparam int ActionBits   = 3;
  localparam int EventBits    = 2;

  localparam logic [ThrBits-1:0]  MoveThrReset    = 8'd3;
  localparam logic [CodeBits-1:0] EmitButtonReset = 8'd1;
  localparam int                  DwellReset      = 5;
  localparam int                  DragReset       = 5;

  // Fixed-width configuration bundle
  typedef struct packed {
    logic [ThrSqBits-1:0] move_thr_sq;
    logic                 drag_mode;
    logic                 sound_enable;
    logic [CodeBits-1:0]  emit_button;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [EventBits-1:0] button_event;
    logic [CodeBits-1:0]  button_code;
    logic                 sound_cue;
    logic                 is_active;
    logic                 is_moving;
    logic                 is_dragging;
  } result_t;

endpackage

[rtl/dcc_cfg.sv]
// ----------------------------------------------------------------------------
// dcc_cfg
// Configuration register file. Keeps the squared move threshold so the
// motion compare needs no multiplier on the threshold.
// ----------------------------------------------------------------------------
module dcc_cfg #(
  parameter int TICK_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dcc_pkg::CfgIndexBits-1:0]       cfg_index_i,
  input  logic [(TICK_BITS > 8 ? TICK_BITS : 8)-1:0] cfg_data_i,
  output logic [TICK_BITS-1:0]                   dwell_ticks_o,
  output logic [TICK_BITS-1:0]                   drag_ticks_o,
  output dcc_pkg::cfg_t                          cfg_o
);

  logic [dcc_pkg::ThrBits-1:0]   thr_byte;
  logic [dcc_pkg::ThrSqBits-1:0] thr_sq;
  logic                          wr_en;

  logic [TICK_BITS-1:0]          dwell_q;
  logic [TICK_BITS-1:0]          drag_q;
  dcc_pkg::cfg_t                 cfg_q;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Square the threshold at write time
  assign thr_byte = cfg_data_i[dcc_pkg::ThrBits-1:0];
  assign thr_sq   = dcc_pkg::ThrSqBits'(thr_byte) * dcc_pkg::ThrSqBits'(thr_byte);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q              <= TICK_BITS'(dcc_pkg::DwellReset);
      drag_q               <= TICK_BITS'(dcc_pkg::DragReset);
      cfg_q.move_thr_sq    <= dcc_pkg::ThrSqBits'(dcc_pkg::MoveThrReset)
                              * dcc_pkg::ThrSqBits'(dcc_pkg::MoveThrReset);
      cfg_q.drag_mode      <= 1'b0;
      cfg_q.sound_enable   <= 1'b0;
      cfg_q.emit_button    <= dcc_pkg::EmitButtonReset;
    end else if (wr_en) begin
      unique case (dcc_pkg::cfg_index_e'(cfg_index_i))
        dcc_pkg::REG_MOVE_THRESHOLD: cfg_q.move_thr_sq <= thr_sq;
        dcc_pkg::REG_DWELL_TICKS:    dwell_q <= cfg_data_i[TICK_BITS-1:0];
        dcc_pkg::REG_DRAG_TICKS:     drag_q  <= cfg_data_i[TICK_BITS-1:0];
        dcc_pkg::REG_DRAG_MODE:      cfg_q.drag_mode <= cfg_data_i[0];
        dcc_pkg::REG_SOUND_ENABLE:   cfg_q.sound_enable <= cfg_data_i[0];
        dcc_pkg::REG_EMIT_BUTTON:    cfg_q.emit_button <= cfg_data_i[dcc_pkg::CodeBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign dwell_ticks_o = dwell_q;
  assign drag_ticks_o  = drag_q;
  assign cfg_o         = cfg_q;

endmodule

[rtl/dcc_motion.sv]
// ----------------------------------------------------------------------------
// dcc_motion
// Motion judge: squared distance from the anchor against the squared
// threshold (one pixel once the cursor is already moving).
// ----------------------------------------------------------------------------
module dcc_motion #(
  parameter int COORD_BITS = 14
) (
  input  logic [COORD_BITS-1:0]            x_i,
  input  logic [COORD_BITS-1:0]            y_i,
  input  logic [COORD_BITS-1:0]            anchor_x_i,
  input  logic [COORD_BITS-1:0]            anchor_y_i,
  input  logic                             was_moving_i,
  input  logic [dcc_pkg::ThrSqBits-1:0]    thr_sq_i,
  output logic                             moving_o
);

  localparam int SqBits   = 2 * COORD_BITS;
  localparam int DistBits = SqBits + 1;

  logic [COORD_BITS-1:0]         dx;
  logic [COORD_BITS-1:0]         dy;
  logic [SqBits-1:0]             dx_sq;
  logic [SqBits-1:0]             dy_sq;
  logic [DistBits-1:0]           dist_sq;
  logic [dcc_pkg::ThrSqBits-1:0] thr_sq;

  // Absolute differences
  assign dx = (x_i > anchor_x_i) ? (x_i - anchor_x_i) : (anchor_x_i - x_i);
  assign dy = (y_i > anchor_y_i) ? (y_i - anchor_y_i) : (anchor_y_i - y_i);

  // Squared distance
  assign dx_sq   = SqBits'(dx) * SqBits'(dx);
  assign dy_sq   = SqBits'(dy) * SqBits'(dy);
  assign dist_sq = DistBits'(dx_sq) + DistBits'(dy_sq);

  // Keep moving on one pixel, start on the configured threshold
  assign thr_sq   = was_moving_i ? dcc_pkg::ThrSqBits'(1) : thr_sq_i;
  assign moving_o = dist_sq > DistBits'(thr_sq);

endmodule

[rtl/dcc_engine.sv]
// ----------------------------------------------------------------------------
// dcc_engine
// Dwell state and decision logic: enable control, button queue, idle
// counter, click and drag events. Updates state on each stepped request.
// ----------------------------------------------------------------------------
module dcc_engine #(
  parameter int BUTTON_COUNT = 32,
  parameter int COORD_BITS   = 14,
  parameter int TICK_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [dcc_pkg::ActionBits-1:0]     action_i,
  input  logic [COORD_BITS-1:0]              cursor_x_i,
  input  logic [COORD_BITS-1:0]              cursor_y_i,
  input  logic [dcc_pkg::BtnNumBits-1:0]     button_number_i,
  input  logic [TICK_BITS-1:0]               dwell_ticks_i,
  input  logic [TICK_BITS-1:0]               drag_ticks_i,
  input  dcc_pkg::cfg_t                      cfg_i,
  output dcc_pkg::result_t                   res_o
);

  localparam int IdleBits = TICK_BITS + 1;

  // State
  logic                    enabled_q,    enabled_d;
  logic                    fresh_q,      fresh_d;
  logic [COORD_BITS-1:0]   anchor_x_q,   anchor_x_d;
  logic [COORD_BITS-1:0]   anchor_y_q,   anchor_y_d;
  logic                    was_moving_q, was_moving_d;
  logic [IdleBits-1:0]     idle_q,       idle_d;
  logic                    dragging_q,   dragging_d;
  logic [BUTTON_COUNT-1:0] held_q,       held_d;
  logic [BUTTON_COUNT-1:0] rel_q,        rel_d;
  logic [BUTTON_COUNT-1:0] pend_press_q, pend_press_d;
  logic [BUTTON_COUNT-1:0] pend_rel_q,   pend_rel_d;

  // Working values
  logic                    moving;
  logic                    btn_ok;
  logic [BUTTON_COUNT-1:0] btn_bit;
  logic [TICK_BITS-1:0]    tick_max;
  logic [IdleBits-1:0]     cap;
  logic [IdleBits-1:0]     idle_w;
  logic [BUTTON_COUNT-1:0] held_w;
  logic                    drag_w;
  logic                    en_w;
  logic [dcc_pkg::EventBits-1:0] evt;
  logic                    cue;
  logic                    moving_out;

  dcc_motion #(
    .COORD_BITS (COORD_BITS)
  ) u_motion (
    .x_i          (cursor_x_i),
    .y_i          (cursor_y_i),
    .anchor_x_i   (anchor_x_q),
    .anchor_y_i   (anchor_y_q),
    .was_moving_i (was_moving_q),
    .thr_sq_i     (cfg_i.move_thr_sq),
    .moving_o     (moving)
  );

  // Decode button and idle cap
  assign btn_ok   = 32'(button_number_i) < BUTTON_COUNT;
  assign btn_bit  = BUTTON_COUNT'(1) << button_number_i;
  assign tick_max = (dwell_ticks_i > drag_ticks_i) ? dwell_ticks_i : drag_ticks_i;
  assign cap      = IdleBits'(tick_max) + IdleBits'(1);

  // Next state and result
  always_comb begin
    enabled_d    = enabled_q;
    fresh_d      = fresh_q;
    anchor_x_d   = anchor_x_q;
    anchor_y_d   = anchor_y_q;
    was_moving_d = was_moving_q;
    idle_d       = idle_q;
    dragging_d   = dragging_q;
    held_d       = held_q;
    rel_d        = rel_q;
    pend_press_d = pend_press_q;
    pend_rel_d   = pend_rel_q;
    idle_w       = idle_q;
    held_w       = held_q;
    drag_w       = dragging_q;
    en_w         = enabled_q;
    evt          = 2'(dcc_pkg::EVT_NONE);
    cue          = 1'b0;
    moving_out   = 1'b0;

    unique case (dcc_pkg::action_e'(action_i))
      dcc_pkg::ACT_PRESS: begin
        if (btn_ok) begin
          pend_press_d = pend_press_q | btn_bit;
        end
      end
      dcc_pkg::ACT_RELEASE: begin
        if (btn_ok) begin
          pend_rel_d = pend_rel_q | btn_bit;
        end
      end
      dcc_pkg::ACT_TOGGLE, dcc_pkg::ACT_ENABLE, dcc_pkg::ACT_DISABLE: begin
        priority if (dcc_pkg::action_e'(action_i) == dcc_pkg::ACT_TOGGLE) begin
          en_w = !enabled_q;
        end else begin
          en_w = (dcc_pkg::action_e'(action_i) == dcc_pkg::ACT_ENABLE);
        end
        enabled_d = en_w;
        if (en_w && !enabled_q) begin
          fresh_d = 1'b1;
        end
      end
      dcc_pkg::ACT_TICK: begin
        if (enabled_q) begin
          was_moving_d = moving;
          if (moving) begin
            // Follow the cursor and restart the idle count (first move after enable: park it past the cap)
            anchor_x_d = cursor_x_i;
            anchor_y_d = cursor_y_i;
            moving_out = 1'b1;
            if (fresh_q) begin
              fresh_d = 1'b0;
              idle_d  = cap + IdleBits'(1);
            end else begin
              idle_d = '0;
            end
          end else begin
            // Advance the idle count up to the cap
            if (idle_q < cap) begin
              idle_w = idle_q + IdleBits'(1);
            end
            // Merge queued buttons into the inhibit masks
            held_w       = (held_q & ~rel_q) | pend_press_q;
            held_d       = held_w;
            rel_d        = pend_rel_q;
            pend_press_d = '0;
            pend_rel_d   = '0;
            if ((|held_w) && (!cfg_i.drag_mode || !dragging_q)) begin
              idle_w = cap;
            end
            // Dwell reached: click, or press in drag mode
            if (idle_w == IdleBits'(dwell_ticks_i) && !drag_w) begin
              if (cfg_i.drag_mode) begin
                evt    = evt | 2'(dcc_pkg::EVT_PRESS);
                drag_w = 1'b1;
                idle_w = '0;
              end else begin
                evt    = evt | 2'(dcc_pkg::EVT_CLICK);
                idle_w = cap;
              end
              cue = cfg_i.sound_enable;
            end
            // Drag dwell reached: release
            if (idle_w == IdleBits'(drag_ticks_i) && drag_w) begin
              evt    = evt | 2'(dcc_pkg::EVT_RELEASE);
              drag_w = 1'b0;
              idle_w = cap;
            end
            idle_d     = idle_w;
            dragging_d = drag_w;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b1;
      fresh_q      <= 1'b1;
      anchor_x_q   <= '0;
      anchor_y_q   <= '0;
      was_moving_q <= 1'b0;
      idle_q       <= '0;
      dragging_q   <= 1'b0;
      held_q       <= '0;
      rel_q        <= '0;
      pend_press_q <= '0;
      pend_rel_q   <= '0;
    end else if (step_i) begin
      enabled_q    <= enabled_d;
      fresh_q      <= fresh_d;
      anchor_x_q   <= anchor_x_d;
      anchor_y_q   <= anchor_y_d;
      was_moving_q <= was_moving_d;
      idle_q       <= idle_d;
      dragging_q   <= dragging_d;
      held_q       <= held_d;
      rel_q        <= rel_d;
      pend_press_q <= pend_press_d;
      pend_rel_q   <= pend_rel_d;
    end
  end

  // Result of this request
  always_comb begin
    res_o.button_event = evt;
    res_o.button_code  = (evt != 2'(dcc_pkg::EVT_NONE)) ? cfg_i.emit_button : '0;
    res_o.sound_cue    = cue;
    res_o.is_active    = enabled_d;
    res_o.is_moving    = moving_out;
    res_o.is_dragging  = dragging_d;
  end

endmodule

[rtl/dwell_click_controller.sv]
// ----------------------------------------------------------------------------
// dwell_click_controller
// Path: the request is taken into the input register, then one pass through
//   the decision logic loads the result register once the result slot is free.
// Throughput: one request per cycle while out_stall_i does not hold the
//   result; the state update is a single pass.
// Reset: asynchronous, clears the handshake and dwell state, loads register
//   defaults; requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module dwell_click_controller #(
  parameter int BUTTON_COUNT = 32,
  parameter int COORD_BITS   = 14,
  parameter int TICK_BITS    = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dcc_pkg::CfgIndexBits-1:0]       cfg_index_i,
  input  logic [(TICK_BITS > 8 ? TICK_BITS : 8)-1:0] cfg_data_i,
  // Request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [dcc_pkg::ActionBits-1:0]         action_i,
  input  logic [COORD_BITS-1:0]                  cursor_x_i,
  input  logic [COORD_BITS-1:0]                  cursor_y_i,
  input  logic [dcc_pkg::BtnNumBits-1:0]         button_number_i,
  // Result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [dcc_pkg::EventBits-1:0]          button_event_o,
  output logic [dcc_pkg::CodeBits-1:0]           button_code_o,
  output logic                                   sound_cue_o,
  output logic                                   is_active_o,
  output logic                                   is_moving_o,
  output logic                                   is_dragging_o
);

  logic [TICK_BITS-1:0]            dwell_ticks;
  logic [TICK_BITS-1:0]            drag_ticks;
  dcc_pkg::cfg_t                   cfg;

  logic                            in_valid_q;
  logic [dcc_pkg::ActionBits-1:0]  in_action_q;
  logic [COORD_BITS-1:0]           in_x_q;
  logic [COORD_BITS-1:0]           in_y_q;
  logic [dcc_pkg::BtnNumBits-1:0]  in_btn_q;

  logic                            out_valid_q;
  dcc_pkg::result_t                res_q;
  dcc_pkg::result_t                res_d;

  logic                            out_free;
  logic                            step;
  logic                            in_accept;

  dcc_cfg #(
    .TICK_BITS (TICK_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .dwell_ticks_o (dwell_ticks),
    .drag_ticks_o  (drag_ticks),
    .cfg_o         (cfg)
  );

  // Handshake: step when the result slot is free or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_action_q <= action_i;
      in_x_q      <= cursor_x_i;
      in_y_q      <= cursor_y_i;
      in_btn_q    <= button_number_i;
    end
  end

  dcc_engine #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .COORD_BITS   (COORD_BITS),
    .TICK_BITS    (TICK_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .action_i        (in_action_q),
    .cursor_x_i      (in_x_q),
    .cursor_y_i      (in_y_q),
    .button_number_i (in_btn_q),
    .dwell_ticks_i   (dwell_ticks),
    .drag_ticks_i    (drag_ticks),
    .cfg_i           (cfg),
    .res_o           (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign button_event_o = res_q.button_event;
  assign button_code_o  = res_q.button_code;
  assign sound_cue_o    = res_q.sound_cue;
  assign is_active_o    = res_q.is_active;
  assign is_moving_o    = res_q.is_moving;
  assign is_dragging_o  = res_q.is_dragging;

  // Checks
  a_code_only_with_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (button_event_o == 2'(dcc_pkg::EVT_NONE)) |-> button_code_o == '0)
    else $error("button code set without an event");

  a_cue_only_on_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sound_cue_o |->
      (button_event_o == 2'(dcc_pkg::EVT_PRESS)) ||
      (button_event_o == 2'(dcc_pkg::EVT_CLICK)))
    else $error("sound cue without a click or press");

  a_press_starts_drag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (button_event_o == 2'(dcc_pkg::EVT_PRESS)) |-> is_dragging_o)
    else $error("press issued but not dragging");

  a_held_request_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_action_q) && $stable(in_btn_q))
    else $error("pending request lost or changed");

endmodule
